>>> hdl/pixel_offset_restride_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the offset restride block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PIXEL_OFFSET_RESTRIDE_MACROS_SVH
`define PIXEL_OFFSET_RESTRIDE_MACROS_SVH

// same-cycle implication, disabled during reset
`define POR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("offset restride check failed");

// next-cycle implication, disabled during reset
`define POR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("offset restride check failed");

`endif

>>> hdl/por_pkg.sv
// ----------------------------------------------------------------------------
// Offset restride package
// Widths, constants and payload types shared by the restride modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package por_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int STRIDE_BITS = 16;
  localparam int DATA_BITS   = 32;
  localparam int ADDR_BITS   = 3;
  localparam int REG_BITS    = 32;

  // signed row part, signed column part, product and rebuilt sum
  localparam int QUOT_BITS = OFFSET_BITS + 1;
  localparam int COL_BITS  = STRIDE_BITS + 1;
  localparam int PROD_BITS = QUOT_BITS + COL_BITS;
  localparam int FULL_BITS = PROD_BITS + 1;
  localparam int CALC_BITS = (FULL_BITS > DATA_BITS) ? FULL_BITS : DATA_BITS + 1;

  localparam int DIV_CNT_BITS = $clog2(OFFSET_BITS);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = STRIDE_BITS'(512);

  localparam logic signed [DATA_BITS-1:0] INT_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_BITS-1:0] INT_MIN   = 32'sh8000_0000;
  localparam logic signed [DATA_BITS-1:0] MIN_RESET = INT_MAX;
  localparam logic signed [DATA_BITS-1:0] MAX_RESET = 32'sh8000_0001;

  // register index, taken from paddr bit 2
  localparam int   REG_IDX_BIT    = 2;
  localparam logic REG_OLD_STRIDE = 1'b0;
  localparam logic REG_NEW_STRIDE = 1'b1;

  typedef struct packed {
    logic signed [OFFSET_BITS-1:0] offset;
    logic                          last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] new_offset;
    logic signed [DATA_BITS-1:0] min_offset;
    logic signed [DATA_BITS-1:0] max_offset;
    logic                        changed;
    logic                        saturated;
    logic                        last_out;
  } out_t;

  typedef struct packed {
    logic [STRIDE_BITS-1:0] old_stride;
    logic [STRIDE_BITS-1:0] new_stride;
  } cfg_t;

  typedef struct packed {
    logic                          bypass;
    logic                          neg;
    logic [OFFSET_BITS-1:0]        mag;
    logic signed [OFFSET_BITS-1:0] offset;
    logic                          last;
    logic                          changed;
  } entry_t;

endpackage

`default_nettype wire

>>> hdl/por_front.sv
// ----------------------------------------------------------------------------
// Offset restride front end
// Accepts requests, classifies them as pass-through or divide and splits
// the offset into sign and magnitude for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module por_front import por_pkg::*; (
  input  wire  logic   in_valid_i,
  output       logic   in_ready_o,
  input  wire  in_t    in_data_i,
  input  wire  cfg_t   cfg_i,
  input  wire  logic   full_i,
  output       logic   push_o,
  output       entry_t entry_o
);

  logic changed;

  assign changed    = (cfg_i.old_stride != cfg_i.new_stride);
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    entry_o.changed = changed;
    entry_o.bypass  = !changed || (cfg_i.old_stride == '0);
    entry_o.neg     = in_data_i.offset[OFFSET_BITS-1];
    entry_o.offset  = in_data_i.offset;
    entry_o.last    = in_data_i.last;
    // the most negative offset wraps to its own magnitude as unsigned
    entry_o.mag     = entry_o.neg ? (~in_data_i.offset + 1'b1) : in_data_i.offset;
  end

endmodule

`default_nettype wire

>>> hdl/por_fifo.sv
// ----------------------------------------------------------------------------
// Offset restride queue
// Short register queue between the front end and the compute back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module por_fifo import por_pkg::*; (
  input  wire  logic   clk_i,
  input  wire  logic   rst_ni,
  input  wire  logic   push_i,
  input  wire  entry_t push_data_i,
  output       logic   full_o,
  input  wire  logic   pop_i,
  output       entry_t pop_data_o,
  output       logic   empty_o
);

  entry_t              mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == CNT_BITS'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/por_back.sv
// ----------------------------------------------------------------------------
// Offset restride back end
// Restoring divider by the old stride, centring fold, multiply by the new
// stride, saturation, running min and max, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module por_back import por_pkg::*; (
  input  wire  logic   clk_i,
  input  wire  logic   rst_ni,
  input  wire  cfg_t   cfg_i,
  input  wire  logic   empty_i,
  input  wire  entry_t entry_i,
  output       logic   pop_o,
  output       logic   out_valid_o,
  input  wire  logic   out_ready_i,
  output       out_t   out_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                  state_q, state_d;
  entry_t                      cur_q;
  logic [OFFSET_BITS-1:0]      quo_q;
  logic [STRIDE_BITS-1:0]      rem_q;
  logic [DIV_CNT_BITS-1:0]     cnt_q;
  logic signed [PROD_BITS-1:0] prod_q;
  logic signed [COL_BITS-1:0]  col_q;
  logic signed [DATA_BITS-1:0] run_min_q, run_max_q;
  logic                        out_valid_q;
  out_t                        out_q;

  // divider step
  logic [STRIDE_BITS:0]   rem_sh, rem_nx;
  logic                   ge;
  logic [OFFSET_BITS-1:0] quo_nx;

  // fold and multiply
  logic                        fold, col_neg;
  logic [QUOT_BITS-1:0]        qmag;
  logic signed [QUOT_BITS-1:0] q_row;
  logic [STRIDE_BITS-1:0]      cmag;
  logic signed [COL_BITS-1:0]  col, nstride;
  logic signed [PROD_BITS-1:0] prod;

  // rebuild and track
  logic signed [CALC_BITS-1:0] full;
  logic                        sat_hi, sat_lo;
  logic signed [DATA_BITS-1:0] off_ext, res, new_min, new_max;
  logic                        out_load;

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    rem_sh = {rem_q, quo_q[OFFSET_BITS-1]};
    ge     = (rem_sh >= {1'b0, cfg_i.old_stride});
    rem_nx = ge ? (rem_sh - {1'b0, cfg_i.old_stride}) : rem_sh;
    quo_nx = {quo_q[OFFSET_BITS-2:0], ge};
  end

  // a remainder above half the stride moves the row one step away from zero
  always_comb begin
    fold    = (rem_q > (cfg_i.old_stride >> 1));
    col_neg = cur_q.neg ^ fold;
    qmag    = {1'b0, quo_q} + QUOT_BITS'(fold);
    q_row   = cur_q.neg ? -$signed(qmag) : $signed(qmag);
    cmag    = fold ? (cfg_i.old_stride - rem_q) : rem_q;
    col     = col_neg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
    nstride = $signed({1'b0, cfg_i.new_stride});
    prod    = q_row * nstride;
  end

  always_comb begin
    full    = CALC_BITS'(prod_q) + CALC_BITS'(col_q);
    sat_hi  = (full > CALC_BITS'(INT_MAX));
    sat_lo  = (full < CALC_BITS'(INT_MIN));
    off_ext = DATA_BITS'(cur_q.offset);
    if (cur_q.bypass) begin
      res = off_ext;
    end else if (sat_hi) begin
      res = INT_MAX;
    end else if (sat_lo) begin
      res = INT_MIN;
    end else begin
      res = full[DATA_BITS-1:0];
    end
    new_min  = (res < run_min_q) ? res : run_min_q;
    new_max  = (res > run_max_q) ? res : run_max_q;
    out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = entry_i.bypass ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      run_min_q   <= MIN_RESET;
      run_max_q   <= MAX_RESET;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        // restart the set after its last request
        run_min_q   <= cur_q.last ? MIN_RESET : new_min;
        run_max_q   <= cur_q.last ? MAX_RESET : new_max;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
      quo_q <= entry_i.mag;
      rem_q <= '0;
      cnt_q <= DIV_CNT_BITS'(OFFSET_BITS - 1);
    end else if (state_q == ST_DIV) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx[STRIDE_BITS-1:0];
      cnt_q <= cnt_q - 1'b1;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod;
      col_q  <= col;
    end
    if (out_load) begin
      out_q.new_offset <= res;
      out_q.min_offset <= new_min;
      out_q.max_offset <= new_max;
      out_q.changed    <= cur_q.changed;
      out_q.saturated  <= !cur_q.bypass && (sat_hi || sat_lo);
      out_q.last_out   <= cur_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hdl/pixel_offset_restride.sv
// ----------------------------------------------------------------------------
// Pixel offset restride
// Re-expresses signed linear pixel offsets built with one row length under
// another, with saturation and a per-set running minimum and maximum.
// ----------------------------------------------------------------------------
//   channel   direction   payload   handshake
//   in        sink        in_t      in_valid_i / in_ready_o
//   out       source      out_t     out_valid_o / out_ready_i
//   cfg       APB slave   32 bit    psel, penable, pwrite, pready
//
// A request with different strides and a nonzero old stride passes through
// the back-end states DIV, MUL and FIN, using the one-bit-per-cycle divider;
// other requests go straight to FIN. The queue registers accepted requests.
// Reset restores both strides to 512 and clears the running extremes.
// A stalled result holds in the output register while the next request is
// divided; the front end stalls only when the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_offset_restride import por_pkg::*; (
  input  wire  logic                 clk_i,
  input  wire  logic                 rst_ni,
  input  wire  logic                 in_valid_i,
  output       logic                 in_ready_o,
  input  wire  in_t                  in_data_i,
  output       logic                 out_valid_o,
  input  wire  logic                 out_ready_i,
  output       out_t                 out_data_o,
  input  wire  logic                 psel,
  input  wire  logic                 penable,
  input  wire  logic                 pwrite,
  input  wire  logic [ADDR_BITS-1:0] paddr,
  input  wire  logic [REG_BITS-1:0]  pwdata,
  output       logic [REG_BITS-1:0]  prdata,
  output       logic                 pready
);

  cfg_t   cfg_q;
  logic   cfg_wr;
  logic   full, empty, push, pop;
  entry_t push_entry, pop_entry;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.old_stride <= STRIDE_RESET;
      cfg_q.new_stride <= STRIDE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[REG_IDX_BIT])
        REG_OLD_STRIDE: cfg_q.old_stride <= pwdata[STRIDE_BITS-1:0];
        REG_NEW_STRIDE: cfg_q.new_stride <= pwdata[STRIDE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_IDX_BIT])
      REG_OLD_STRIDE: prdata = REG_BITS'(cfg_q.old_stride);
      REG_NEW_STRIDE: prdata = REG_BITS'(cfg_q.new_stride);
      default:        prdata = '0;
    endcase
  end

  por_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  por_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .empty_o     (empty)
  );

  por_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> hdl/por_checker.sv
// ----------------------------------------------------------------------------
// Offset restride port checker
// Watches the result channel of the top level and checks its invariants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_offset_restride_macros.svh"

module por_checker import por_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  logic out_stall, order_ok, same_stride, clipped, at_limit;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign order_ok    = ($signed(out_data_o.min_offset) <= $signed(out_data_o.new_offset)) &&
                       ($signed(out_data_o.new_offset) <= $signed(out_data_o.max_offset));
  assign same_stride = out_valid_o && !out_data_o.changed;
  assign clipped     = out_valid_o && out_data_o.saturated;
  assign at_limit    = (out_data_o.new_offset == INT_MAX) ||
                       (out_data_o.new_offset == INT_MIN);

  // a stalled result stays put
  `POR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))

  // the running extremes include the current offset
  `POR_ASSERT_IMP(a_min_max_order, clk_i, rst_ni, out_valid_o, order_ok)

  // equal strides pass through and never clip
  `POR_ASSERT_IMP(a_same_stride_no_sat, clk_i, rst_ni, same_stride, !out_data_o.saturated)

  // a clipped offset sits on one of the 32-bit limits
  `POR_ASSERT_IMP(a_sat_at_limit, clk_i, rst_ni, clipped, at_limit)

endmodule

bind pixel_offset_restride por_checker u_por_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Pixel offset restride testbench
// Drives offset requests through the valid/ready channel under several stride
// settings written over APB, predicts each rebuilt offset with its running
// extremes, and compares every result field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import por_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 80;
  localparam int MAX_REPORTS   = 10;

  localparam logic signed [OFFSET_BITS-1:0] OFF_MAX = {1'b0, {(OFFSET_BITS-1){1'b1}}};
  localparam logic signed [OFFSET_BITS-1:0] OFF_MIN = {1'b1, {(OFFSET_BITS-1){1'b0}}};

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 out_data_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [ADDR_BITS-1:0] paddr       = '0;
  logic [REG_BITS-1:0]  pwdata      = '0;
  logic [REG_BITS-1:0]  prdata;
  logic                 pready;

  // predictor copy of the registers and the per-set extremes
  logic [STRIDE_BITS-1:0]      old_stride_m = STRIDE_RESET;
  logic [STRIDE_BITS-1:0]      new_stride_m = STRIDE_RESET;
  logic signed [DATA_BITS-1:0] run_min      = MIN_RESET;
  logic signed [DATA_BITS-1:0] run_max      = MAX_RESET;

  out_t restrided_q[$];
  int   mismatch_cnt = 0;
  logic no_gaps      = 1'b0;
  logic hold_out     = 1'b0;

  pixel_offset_restride dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic out_t restride_offset(input in_t req);
    out_t   res;
    longint off, s, half, q, r, mag, full;
    res = '0;
    off = longint'($signed(req.offset));
    res.changed  = (old_stride_m != new_stride_m);
    res.last_out = req.last;
    full = off;
    // a zero old stride skips the division and passes the offset through
    if (res.changed && old_stride_m != '0) begin
      s    = longint'(old_stride_m);
      half = s / 2;
      q    = off / s;
      r    = off % s;
      mag  = (r < 0) ? -r : r;
      // fold the column toward zero and move the row one step
      if (mag > half) begin
        q += (off > 0) ? 1 : -1;
        r += (r > 0) ? -s : s;
      end
      full = q * longint'(new_stride_m) + r;
      if (full > longint'(INT_MAX)) begin
        full = longint'(INT_MAX);
        res.saturated = 1'b1;
      end else if (full < longint'(INT_MIN)) begin
        full = longint'(INT_MIN);
        res.saturated = 1'b1;
      end
    end
    res.new_offset = full[DATA_BITS-1:0];
    if (full < longint'(run_min)) run_min = full[DATA_BITS-1:0];
    if (full > longint'(run_max)) run_max = full[DATA_BITS-1:0];
    res.min_offset = run_min;
    res.max_offset = run_max;
    if (req.last) begin
      run_min = MIN_RESET;
      run_max = MAX_RESET;
    end
    return res;
  endfunction

  function automatic longint pick_offset(input logic [STRIDE_BITS-1:0] stride);
    longint rows, col;
    rows = longint'($urandom_range(64)) - 32;
    col  = longint'(stride / 2) + longint'($urandom_range(2)) - 1;
    case ($urandom_range(9))
      0:       pick_offset = $urandom_range(1) ? OFF_MAX : OFF_MIN;
      // land the remainder around half a stride, where folding starts
      1, 2, 3: pick_offset = rows * longint'(stride) + ($urandom_range(1) ? col : -col);
      4:       pick_offset = longint'($urandom_range(2000)) - 1000;
      default: pick_offset = longint'($signed(OFFSET_BITS'($urandom)));
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic signed [DATA_BITS-1:0] exp_v,
                               input logic signed [DATA_BITS-1:0] act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endtask

  // record each accepted request
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      restrided_q.push_back(restride_offset(in_data_i));
  end

  always @(posedge clk_i) begin : result_check
    out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (restrided_q.size() == 0) begin
        note_mismatch("unexpected result new_offset", '0, out_data_o.new_offset);
      end else begin
        exp_r = restrided_q.pop_front();
        if (out_data_o.new_offset !== exp_r.new_offset)
          note_mismatch("new_offset", exp_r.new_offset, out_data_o.new_offset);
        if (out_data_o.min_offset !== exp_r.min_offset)
          note_mismatch("min_offset", exp_r.min_offset, out_data_o.min_offset);
        if (out_data_o.max_offset !== exp_r.max_offset)
          note_mismatch("max_offset", exp_r.max_offset, out_data_o.max_offset);
        if (out_data_o.changed !== exp_r.changed)
          note_mismatch("changed", exp_r.changed, out_data_o.changed);
        if (out_data_o.saturated !== exp_r.saturated)
          note_mismatch("saturated", exp_r.saturated, out_data_o.saturated);
        if (out_data_o.last_out !== exp_r.last_out)
          note_mismatch("last_out", exp_r.last_out, out_data_o.last_out);
      end
    end
  end

  // receiver: random stalls, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_out = 1'b0;
      end else begin
        out_ready_i <= no_gaps || ($urandom_range(99) >= 20);
      end
    end
  end

  // call and return at a rising edge; valid stays high into the next request
  task automatic offer_offset(input longint off, input logic lst);
    while (!no_gaps && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{offset: OFFSET_BITS'(off), last: lst};
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task automatic drain_results(input int settle);
    @(posedge clk_i);
    while (restrided_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [STRIDE_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(idx) << REG_IDX_BIT;
    pwdata  <= REG_BITS'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_OLD_STRIDE) old_stride_m = value;
    else                       new_stride_m = value;
  endtask

  task automatic set_strides(input logic [STRIDE_BITS-1:0] old_s,
                             input logic [STRIDE_BITS-1:0] new_s);
    in_valid_i <= 1'b0;
    drain_results(4);
    write_reg(REG_OLD_STRIDE, old_s);
    write_reg(REG_NEW_STRIDE, new_s);
  endtask

  task automatic test_directed();
    // equal strides after reset: pass through, extremes still tracked
    offer_offset(OFF_MAX, 1'b0);
    offer_offset(OFF_MIN, 1'b0);
    offer_offset(0, 1'b0);
    offer_offset(-1, 1'b1);
    // fold boundary at half a stride, both signs
    set_strides(16'd512, 16'd65535);
    offer_offset(1000, 1'b0);
    offer_offset(256, 1'b0);
    offer_offset(257, 1'b0);
    offer_offset(-257, 1'b0);
    offer_offset(-256, 1'b0);
    offer_offset(OFF_MAX, 1'b0);
    offer_offset(OFF_MIN, 1'b1);
    // clip to the 32-bit range both ways
    set_strides(16'd1, 16'd65535);
    offer_offset(OFF_MAX, 1'b0);
    offer_offset(32768, 1'b0);
    offer_offset(32769, 1'b0);
    offer_offset(-32769, 1'b0);
    offer_offset(OFF_MIN, 1'b1);
    // zero old stride: no division
    set_strides(16'd0, 16'd512);
    offer_offset(12345, 1'b0);
    offer_offset(-7, 1'b1);
    // zero new stride leaves the centered column only
    set_strides(16'd300, 16'd0);
    offer_offset(1000, 1'b0);
    offer_offset(-1000, 1'b0);
    offer_offset(170, 1'b1);
    set_strides(16'd65535, 16'd1);
    offer_offset(OFF_MAX, 1'b0);
    offer_offset(OFF_MIN, 1'b0);
    offer_offset(40000, 1'b1);
  endtask

  task automatic test_backpressure();
    set_strides(16'd7, 16'd9);
    hold_out = 1'b1;
    no_gaps  = 1'b1;
    for (int k = 0; k < 16; k++)
      offer_offset(pick_offset(16'd7), k % 5 == 4);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_sets();
    int unsigned            sent, set_len;
    logic [STRIDE_BITS-1:0] old_s, new_s;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      old_s = STRIDE_BITS'($urandom_range(1, 65535));
      new_s = STRIDE_BITS'($urandom_range(1, 65535));
      case ($urandom_range(5))
        0: new_s = old_s;
        1: old_s = STRIDE_BITS'($urandom_range(1, 16));
        2: ;
        3: new_s = STRIDE_BITS'($urandom_range(1, 8));
        4: begin
          old_s = $urandom_range(1) ? 16'd65535 : 16'd1;
          new_s = $urandom_range(1) ? 16'd65535 : 16'd1;
        end
        default: new_s = STRIDE_BITS'($urandom_range(1, 1024));
      endcase
      set_strides(old_s, new_s);
      no_gaps = (phase == RANDOM_PHASES / 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        set_len = $urandom_range(1, 8);
        for (int k = 0; k < set_len; k++)
          offer_offset(pick_offset(old_s), k == set_len - 1 && $urandom_range(9) != 0);
        sent += set_len;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_sets();
    in_valid_i <= 1'b0;
    drain_results(SETTLE_CYCLES);
    if (mismatch_cnt == 0 && restrided_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
